// File: sv/nearest_downscale_binarize_16x16_macros.svh
// Assertion macros shared by the downscale and binarize block.
`ifndef NEAREST_DOWNSCALE_BINARIZE_16X16_MACROS_SVH
`define NEAREST_DOWNSCALE_BINARIZE_16X16_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NDB_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NDB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/ndb_pkg.sv
// Package with the shared constants of the downscale and binarize block.
`default_nettype none

package ndb_pkg;

  localparam int OUT_SIZE_DEF = 16;
  localparam int MAX_DIM_DEF = 2048;

  localparam int PIX_W = 8;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;

  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 12'd16;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_ROWS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_COLS = 4'd1;

endpackage

`default_nettype wire

// File: sv/nearest_downscale_binarize_16x16.sv
// Top level of the nearest-neighbor downscale with binary threshold.
`default_nettype none

// Takes gray pixels in raster order, one per cycle, and produces an OUT_SIZE x OUT_SIZE
// binary image by nearest-neighbor sampling: a cell is 1 only where the sampled pixel is
// 255. Each sampled source row yields one word per output row that samples it, at the
// last pixel of that row, with last_of_run on the final word of the run and
// last_of_frame on output row OUT_SIZE-1. A word passes through the input, run and output
// registers. Pixels are taken every cycle but at a stall; the emitter sends one word per
// cycle while out_stall is low, so a row end stalls the input only while the previous run
// is still being sent, as when a source row is shorter than the run it follows or
// out_stall holds words back. Writing a size register restarts the frame.
module nearest_downscale_binarize_16x16 #(
  parameter int OUT_SIZE = ndb_pkg::OUT_SIZE_DEF,
  parameter int MAX_DIM = ndb_pkg::MAX_DIM_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [ndb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ndb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [ndb_pkg::PIX_W-1:0]       pixel,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [$clog2(OUT_SIZE)-1:0]     out_row,
  output logic      [OUT_SIZE-1:0]             row_bits,
  output logic                                 last_of_run,
  output logic                                 last_of_frame
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int CMP_W = (DIM_W > ndb_pkg::CFG_DATA_W) ? DIM_W : ndb_pkg::CFG_DATA_W;

  logic [DIM_W-1:0] rows;
  logic [DIM_W-1:0] cols;

  logic [DIM_W-1:0]    dim_eff;
  logic                restart;
  logic                run_valid;
  logic                run_ready;
  logic [OUT_SIZE-1:0] run_mask;
  logic [OUT_SIZE-1:0] run_word;

  // Zero is taken as one and values above MAX_DIM as MAX_DIM.
  always_comb begin
    if (cfg_data == '0) begin
      dim_eff = DIM_W'(1);
    end else if (CMP_W'(cfg_data) > CMP_W'(MAX_DIM)) begin
      dim_eff = DIM_W'(MAX_DIM);
    end else begin
      dim_eff = DIM_W'(cfg_data);
    end
  end

  assign restart = cfg_we &&
                   ((cfg_index == ndb_pkg::REG_SRC_ROWS) || (cfg_index == ndb_pkg::REG_SRC_COLS));

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= DIM_W'(ndb_pkg::DIM_RESET);
      cols <= DIM_W'(ndb_pkg::DIM_RESET);
    end else if (cfg_we) begin
      if (cfg_index == ndb_pkg::REG_SRC_ROWS) begin
        rows <= dim_eff;
      end
      if (cfg_index == ndb_pkg::REG_SRC_COLS) begin
        cols <= dim_eff;
      end
    end
  end

  ndb_front #(
    .OUT_SIZE (OUT_SIZE),
    .DIM_W    (DIM_W),
    .CNT_W    (CNT_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .rows      (rows),
    .cols      (cols),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pixel     (pixel),
    .run_valid (run_valid),
    .run_ready (run_ready),
    .run_mask  (run_mask),
    .run_word  (run_word)
  );

  ndb_emitter #(
    .OUT_SIZE (OUT_SIZE)
  ) u_emitter (
    .clk           (clk),
    .rst           (rst),
    .run_valid     (run_valid),
    .run_ready     (run_ready),
    .run_mask      (run_mask),
    .run_word      (run_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row       (out_row),
    .row_bits      (row_bits),
    .last_of_run   (last_of_run),
    .last_of_frame (last_of_frame)
  );

endmodule

`default_nettype wire

// File: sv/ndb_match.sv
// Finds which output positions sample a given source position.
`default_nettype none

module ndb_match #(
  parameter int OUT_SIZE = 16,
  parameter int DIM_W = 12,
  parameter int CNT_W = 11
) (
  input  wire logic [DIM_W-1:0]    dim,
  input  wire logic [CNT_W-1:0]    count,
  output logic      [OUT_SIZE-1:0] mask
);

  localparam int OW = $clog2(OUT_SIZE);
  localparam int PROD_W = DIM_W + OW + 1;

  logic [PROD_W-1:0] lo;
  logic [PROD_W-1:0] hi;

  // Position i samples count when count*OUT_SIZE <= i*dim < (count+1)*OUT_SIZE.
  assign lo = PROD_W'(count) * PROD_W'(OUT_SIZE);
  assign hi = lo + PROD_W'(OUT_SIZE);

  for (genvar i = 0; i < OUT_SIZE; i++) begin : g_pos
    logic [PROD_W-1:0] prod;
    assign prod = PROD_W'(dim) * PROD_W'(i);
    assign mask[i] = (prod >= lo) && (prod < hi);
  end

endmodule

`default_nettype wire

// File: sv/ndb_front.sv
// Input register, row and column counters and row word assembly.
`default_nettype none

`include "nearest_downscale_binarize_16x16_macros.svh"

module ndb_front #(
  parameter int OUT_SIZE = 16,
  parameter int DIM_W = 12,
  parameter int CNT_W = 11
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     restart,
  input  wire logic [DIM_W-1:0]         rows,
  input  wire logic [DIM_W-1:0]         cols,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [ndb_pkg::PIX_W-1:0] pixel,
  output logic                          run_valid,
  input  wire logic                     run_ready,
  output logic      [OUT_SIZE-1:0]      run_mask,
  output logic      [OUT_SIZE-1:0]      run_word
);

  logic                      in_q;
  logic [ndb_pkg::PIX_W-1:0] pix_q;
  logic [CNT_W-1:0]          col_count;
  logic [CNT_W-1:0]          row_count;
  logic [OUT_SIZE-1:0]       row_word;

  logic [OUT_SIZE-1:0] col_mask;
  logic [OUT_SIZE-1:0] row_mask;
  logic [OUT_SIZE-1:0] row_word_next;
  logic                hit;
  logic                col_last;
  logic                row_last;
  logic                row_end;
  logic                advance;

  ndb_match #(
    .OUT_SIZE (OUT_SIZE),
    .DIM_W    (DIM_W),
    .CNT_W    (CNT_W)
  ) u_col_match (
    .dim   (cols),
    .count (col_count),
    .mask  (col_mask)
  );

  ndb_match #(
    .OUT_SIZE (OUT_SIZE),
    .DIM_W    (DIM_W),
    .CNT_W    (CNT_W)
  ) u_row_match (
    .dim   (rows),
    .count (row_count),
    .mask  (row_mask)
  );

  assign hit = (pix_q == ndb_pkg::PIX_WHITE);
  assign row_word_next = (row_word & ~col_mask) | (col_mask & {OUT_SIZE{hit}});

  assign col_last = (DIM_W'(col_count) + DIM_W'(1)) == cols;
  assign row_last = (DIM_W'(row_count) + DIM_W'(1)) == rows;
  assign row_end = in_q && col_last;

  // A row end with sampling output rows hands a run to the emitter.
  assign run_valid = row_end && (row_mask != '0);
  assign run_mask = row_mask;
  assign run_word = row_word_next;

  assign advance = in_q && (!run_valid || run_ready);
  assign in_stall = in_q && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q <= 1'b1;
    end else if (advance) begin
      in_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      pix_q <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_count <= '0;
      row_count <= '0;
      row_word <= '0;
    end else if (advance) begin
      if (col_last) begin
        col_count <= '0;
        row_word <= '0;
        if (row_last) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + CNT_W'(1);
        end
      end else begin
        col_count <= col_count + CNT_W'(1);
        row_word <= row_word_next;
      end
    end
  end

  `NDB_ASSERT_NEXT(a_row_end_clears, clk, rst, advance && col_last && !restart, col_count == '0 && row_word == '0, "Row end did not clear the column count and row word.")
  `NDB_ASSERT_SAME(a_stall_only_held, clk, rst, in_stall, in_q && run_valid, "Input stalled without a waiting run.")

endmodule

`default_nettype wire

// File: sv/ndb_emitter.sv
// Sends the row word once for each output row of a run, through an output register.
`default_nettype none

`include "nearest_downscale_binarize_16x16_macros.svh"

module ndb_emitter #(
  parameter int OUT_SIZE = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        run_valid,
  output logic                             run_ready,
  input  wire logic [OUT_SIZE-1:0]         run_mask,
  input  wire logic [OUT_SIZE-1:0]         run_word,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [$clog2(OUT_SIZE)-1:0] out_row,
  output logic      [OUT_SIZE-1:0]         row_bits,
  output logic                             last_of_run,
  output logic                             last_of_frame
);

  localparam int OW = $clog2(OUT_SIZE);

  logic [OUT_SIZE-1:0] rem;
  logic [OUT_SIZE-1:0] wrd;

  logic [OUT_SIZE-1:0] rem_after;
  logic [OW-1:0]       idx;
  logic                out_free;
  logic                pop;

  always_comb begin
    idx = '0;
    for (int i = OUT_SIZE - 1; i >= 0; i--) begin
      if (rem[i]) begin
        idx = OW'(i);
      end
    end
  end

  assign rem_after = rem & (rem - OUT_SIZE'(1));
  assign out_free = !out_valid || !out_stall;
  assign pop = (rem != '0) && out_free;
  assign run_ready = (rem == '0) || (pop && (rem_after == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (run_valid && run_ready) begin
      rem <= run_mask;
    end else if (pop) begin
      rem <= rem_after;
    end
  end

  always_ff @(posedge clk) begin
    if (run_valid && run_ready) begin
      wrd <= run_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_row <= idx;
      row_bits <= wrd;
      last_of_run <= (rem_after == '0);
      last_of_frame <= (idx == OW'(OUT_SIZE - 1));
    end
  end

  `NDB_ASSERT_NEXT(a_load_nonempty, clk, rst, run_valid && run_ready, rem != '0, "A run was loaded with no output rows.")
  `NDB_ASSERT_NEXT(a_last_marked, clk, rst, pop && (rem_after == '0), out_valid && last_of_run, "The final word of a run is not marked last.")
  `NDB_ASSERT_SAME(a_run_pending, clk, rst, out_valid && !last_of_run, rem != '0, "A run ended without a word marked last.")

endmodule

`default_nettype wire

// File: sim/nearest_downscale_binarize_16x16_test.sv
// Self-checking testbench for the downscale and binarize block: directed steps, then random frames.
module nearest_downscale_binarize_16x16_test;

  localparam int OUT_N = ndb_pkg::OUT_SIZE_DEF;
  localparam int PIX_W = ndb_pkg::PIX_W;
  localparam int CFG_IDX_W = ndb_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = ndb_pkg::CFG_DATA_W;
  localparam int ROW_W = $clog2(OUT_N);
  localparam int HALF_PERIOD = 2;
  localparam int RAND_ITEMS = 160;
  localparam int TALL_ITEMS = 260;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_PRINTED = 40;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 4'd15;
  localparam logic [CFG_DATA_W-1:0] DIM_ALL_ONES = 12'hFFF;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic [OUT_N-1:0] row_bits;
    logic             last_of_run;
    logic             last_of_frame;
  } scaled_row_t;

  typedef enum logic {DO_PIXEL, DO_WRITE} step_kind_t;

  typedef struct packed {
    step_kind_t             kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic [PIX_W-1:0]       pix;
    logic                   typed;
    scaled_row_t            want;
  } plan_step_t;

  localparam scaled_row_t NO_ROW = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [PIX_W-1:0] pixel = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [ROW_W-1:0] out_row;
  logic [OUT_N-1:0] row_bits;
  logic last_of_run;
  logic last_of_frame;

  nearest_downscale_binarize_16x16 uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .pixel(pixel),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_row(out_row),
    .row_bits(row_bits),
    .last_of_run(last_of_run),
    .last_of_frame(last_of_frame)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Predictor state: size registers, frame position and the row word being gathered.
  logic [CFG_DATA_W-1:0] rows_reg = ndb_pkg::DIM_RESET;
  logic [CFG_DATA_W-1:0] cols_reg = ndb_pkg::DIM_RESET;
  int col_pos = 0;
  int row_pos = 0;
  logic [OUT_N-1:0] gathered = '0;

  scaled_row_t pending_rows [$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  plan_step_t plan [27] = '{
    '{DO_PIXEL, REG_NONE, 12'd0, 8'd255, 1'b0, NO_ROW},
    '{DO_PIXEL, REG_NONE, 12'd0, 8'd0, 1'b0, NO_ROW},
    '{DO_PIXEL, REG_NONE, 12'd0, 8'd255, 1'b0, NO_ROW},
    '{DO_PIXEL, REG_NONE, 12'd0, 8'd254, 1'b0, NO_ROW},
    '{DO_PIXEL, REG_NONE, 12'd0, 8'd255, 1'b0, NO_ROW},
    '{DO_PIXEL, REG_NONE, 12'd0, 8'd127, 1'b0, NO_ROW},
    '{DO_PIXEL, REG_NONE, 12'd0, 8'd128, 1'b0, NO_ROW},
    '{DO_PIXEL, REG_NONE, 12'd0, 8'd255, 1'b0, NO_ROW},
    '{DO_WRITE, REG_NONE, 12'hFFF, 8'd0, 1'b0, NO_ROW},
    '{DO_PIXEL, REG_NONE, 12'd0, 8'd1, 1'b0, NO_ROW},
    '{DO_PIXEL, REG_NONE, 12'd0, 8'd255, 1'b0, NO_ROW},
    '{DO_PIXEL, REG_NONE, 12'd0, 8'd2, 1'b0, NO_ROW},
    '{DO_PIXEL, REG_NONE, 12'd0, 8'd4, 1'b0, NO_ROW},
    '{DO_PIXEL, REG_NONE, 12'd0, 8'd8, 1'b0, NO_ROW},
    '{DO_PIXEL, REG_NONE, 12'd0, 8'd16, 1'b0, NO_ROW},
    '{DO_PIXEL, REG_NONE, 12'd0, 8'd32, 1'b0, NO_ROW},
    '{DO_PIXEL, REG_NONE, 12'd0, 8'd64, 1'b1, '{4'd0, 16'h0295, 1'b1, 1'b0}},
    '{DO_WRITE, ndb_pkg::REG_SRC_COLS, 12'd1, 8'd0, 1'b0, NO_ROW},
    '{DO_PIXEL, REG_NONE, 12'd0, 8'd255, 1'b1, '{4'd0, 16'hFFFF, 1'b1, 1'b0}},
    '{DO_PIXEL, REG_NONE, 12'd0, 8'd0, 1'b1, '{4'd1, 16'h0000, 1'b1, 1'b0}},
    '{DO_WRITE, ndb_pkg::REG_SRC_ROWS, 12'd0, 8'd0, 1'b0, NO_ROW},
    '{DO_PIXEL, REG_NONE, 12'd0, 8'd255, 1'b0, NO_ROW},
    '{DO_WRITE, ndb_pkg::REG_SRC_ROWS, 12'hFFF, 8'd0, 1'b0, NO_ROW},
    '{DO_PIXEL, REG_NONE, 12'd0, 8'd0, 1'b1, '{4'd0, 16'h0000, 1'b1, 1'b0}},
    '{DO_PIXEL, REG_NONE, 12'd0, 8'd255, 1'b0, NO_ROW},
    '{DO_WRITE, ndb_pkg::REG_SRC_COLS, 12'd0, 8'd0, 1'b0, NO_ROW},
    '{DO_PIXEL, REG_NONE, 12'd0, 8'd255, 1'b1, '{4'd0, 16'hFFFF, 1'b1, 1'b0}}
  };

  function automatic int eff_dim(input logic [CFG_DATA_W-1:0] v);
    if (v == 0) return 1;
    if (v > ndb_pkg::MAX_DIM_DEF) return ndb_pkg::MAX_DIM_DEF;
    return int'(v);
  endfunction

  function automatic int sample_at(input int idx, input int dim);
    return (idx * dim) / OUT_N;
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    if ($urandom_range(1) == 0) return ndb_pkg::PIX_WHITE;
    return PIX_W'($urandom_range(255));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_dim();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) return '0;
    if (pick < 9) return DIM_ALL_ONES;
    if (pick < 12) return CFG_DATA_W'($urandom_range(ndb_pkg::MAX_DIM_DEF + 1, 4095));
    if (pick < 25) return CFG_DATA_W'($urandom_range(11, 24));
    return CFG_DATA_W'($urandom_range(1, 10));
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatches < MAX_PRINTED) $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Advances the frame position by one pixel and queues the row words it releases.
  task automatic absorb_pixel(input logic [PIX_W-1:0] p, input logic keep);
    int nrows;
    int ncols;
    int last_x;
    int x;
    int y;
    scaled_row_t r;
    nrows = eff_dim(rows_reg);
    ncols = eff_dim(cols_reg);
    if (col_pos >= ncols) col_pos = 0;
    if (row_pos >= nrows) row_pos = 0;
    for (y = 0; y < OUT_N; y++) begin
      if (sample_at(y, ncols) == col_pos) gathered[y] = (p == ndb_pkg::PIX_WHITE);
    end
    if (col_pos + 1 < ncols) begin
      col_pos++;
    end else begin
      last_x = -1;
      for (x = 0; x < OUT_N; x++) begin
        if (sample_at(x, nrows) == row_pos) last_x = x;
      end
      for (x = 0; x < OUT_N; x++) begin
        if (sample_at(x, nrows) == row_pos) begin
          r.out_row = ROW_W'(x);
          r.row_bits = gathered;
          r.last_of_run = (x == last_x);
          r.last_of_frame = (x == OUT_N - 1);
          if (keep) pending_rows.push_back(r);
        end
      end
      col_pos = 0;
      gathered = '0;
      row_pos = (row_pos + 1 < nrows) ? row_pos + 1 : 0;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the pixel is taken.
  task automatic send_pixel(input logic [PIX_W-1:0] p, input logic typed,
                            input scaled_row_t want);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      pixel <= PIX_W'($urandom_range(255));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_pixel(p, !typed);
    if (typed) pending_rows.push_back(want);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(negedge clk);
  endtask

  // A write to either size register restarts the frame; other indexes are ignored.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == ndb_pkg::REG_SRC_ROWS || idx == ndb_pkg::REG_SRC_COLS) begin
      if (idx == ndb_pkg::REG_SRC_ROWS) rows_reg = v;
      else cols_reg = v;
      col_pos = 0;
      row_pos = 0;
      gathered = '0;
    end
  endtask

  task automatic set_sizes(input logic [CFG_DATA_W-1:0] nrows,
                           input logic [CFG_DATA_W-1:0] ncols);
    if ($urandom_range(3) == 0) write_reg(CFG_IDX_W'($urandom_range(2, 15)), random_dim());
    if ($urandom_range(1) == 0) begin
      write_reg(ndb_pkg::REG_SRC_ROWS, nrows);
      write_reg(ndb_pkg::REG_SRC_COLS, ncols);
    end else begin
      write_reg(ndb_pkg::REG_SRC_COLS, ncols);
      write_reg(ndb_pkg::REG_SRC_ROWS, nrows);
    end
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      1: begin
        send_idle_pct = 80;
        stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        stall_pct = 80;
      end
      default: begin
        send_idle_pct = 36;
        stall_pct = 36;
      end
    endcase
  endtask

  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    scaled_row_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_rows.size() == 0) begin
        flag_mismatch($sformatf("unexpected word: row %0d bits %h", out_row, row_bits));
      end else begin
        want = pending_rows.pop_front();
        if (out_row !== want.out_row || row_bits !== want.row_bits ||
            last_of_run !== want.last_of_run || last_of_frame !== want.last_of_frame)
          flag_mismatch($sformatf(
            "got row %0d bits %h run %b frame %b, wanted row %0d bits %h run %b frame %b",
            out_row, row_bits, last_of_run, last_of_frame,
            want.out_row, want.row_bits, want.last_of_run, want.last_of_frame));
      end
    end
  end

  initial begin
    #(4_000_000);
    $display("nearest_downscale_binarize_16x16_test: FAIL");
    $finish;
  end

  initial begin
    int i;
    int k;
    int count;
    int frame;
    int phase;
    int sent;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < $size(plan); i++) begin
      if (plan[i].kind == DO_WRITE) write_reg(plan[i].idx, plan[i].data);
      else send_pixel(plan[i].pix, plan[i].typed, plan[i].want);
    end

    phase = 0;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      set_idling(phase % 4);
      set_sizes(random_dim(), random_dim());
      frame = eff_dim(rows_reg) * eff_dim(cols_reg);
      count = $urandom_range(1, (frame * 2 > 80) ? 80 : frame * 2);
      for (k = 0; k < count; k++) begin
        if ($urandom_range(49) == 0) wait_drained();
        send_pixel(random_pixel(), 1'b0, NO_ROW);
        sent++;
      end
      phase++;
    end

    // Largest row count: a tall one-column frame that reaches output row two at source row 256.
    set_idling(3);
    set_sizes(DIM_ALL_ONES, 12'd1);
    for (k = 0; k < TALL_ITEMS; k++) send_pixel(random_pixel(), 1'b0, NO_ROW);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) $display("nearest_downscale_binarize_16x16_test: PASS");
    else $display("nearest_downscale_binarize_16x16_test: FAIL");
    $finish;
  end

endmodule
